FILE: src/tfg_pkg.sv
// Shared widths, stage counts, constants and bundle types for the triangle
// facet geometry pipeline. No dependencies; every other file imports it.
package tfg_pkg;

    // Coordinate format
    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_W         = 24;

    // Cross product datapath widths
    localparam int EDGE_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W - 1;
    localparam int LO_W    = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - LO_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;

    // Square root and unit-normal quotient widths
    localparam int ROOT_W = SUM_W / 2;
    localparam int RREM_W = ROOT_W + 4;
    localparam int KQ_W   = 18;
    localparam int NRM_W  = SUM_W + KQ_W + 6;
    localparam int UNIT_W = 17;
    localparam int NORMAL_W = UNIT_W + 1;
    localparam logic [UNIT_W-1:0] NORMAL_ONE = UNIT_W'(65536);

    // Area
    localparam int AREA_W = 33;
    localparam logic [ROOT_W-1:0] AREA_MAX = ROOT_W'((64'd1 << AREA_W) - 64'd1);

    // Centroid: floor((2*sum + 3) / 6) done as (sum + 1 + bias) / 3
    localparam int CEN_W       = COORD_W + 3;
    localparam int RECIP_SHIFT = 30;
    localparam int CPROD_W     = CEN_W + RECIP_SHIFT;
    localparam logic [RECIP_SHIFT-1:0] RECIP_3 = RECIP_SHIFT'(357913942);
    localparam logic [CEN_W-1:0] CEN_BIAS = CEN_W'((3 << COORD_W) + 1);

    // Pipeline depth
    localparam int FRONT_STAGES = 7;
    localparam int ROOT_STAGES  = ROOT_W;
    localparam int NRM_STAGES   = KQ_W;
    localparam int NRM_DELAY    = ROOT_STAGES - NRM_STAGES;
    localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_STAGES + 1;

    // Register file
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic [0:0] REG_LIMIT = 1'b0;

    typedef struct packed {
        logic [COORD_W-1:0] a_x;
        logic [COORD_W-1:0] a_y;
        logic [COORD_W-1:0] a_z;
        logic [COORD_W-1:0] b_x;
        logic [COORD_W-1:0] b_y;
        logic [COORD_W-1:0] b_z;
        logic [COORD_W-1:0] c_x;
        logic [COORD_W-1:0] c_y;
        logic [COORD_W-1:0] c_z;
    } vtx_t;

    typedef struct packed {
        logic [SUM_W-1:0]           s;
        logic [2:0][SQ_W-1:0]       sq;
        logic [2:0]                 neg;
        logic [2:0][COORD_W-1:0]    cen;
    } front_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0]    cen;
        logic [2:0]                 neg;
        logic                       degen;
    } side_t;

endpackage

FILE: src/tfg_front.sv
// Front pipeline: edge vectors, cross product, squared length and centroid.
// Seven register stages; depends on tfg_pkg.
module tfg_front (
    input  logic            aclk,
    input  logic            en,
    input  tfg_pkg::vtx_t   vtx_i,
    output tfg_pkg::front_t front_o
);
    import tfg_pkg::*;

    logic [COORD_W-1:0] va [3];
    logic [COORD_W-1:0] vb [3];
    logic [COORD_W-1:0] vc [3];

    logic signed [EDGE_W-1:0]  e_reg [3];
    logic signed [EDGE_W-1:0]  f_reg [3];
    logic [CEN_W-1:0]          u_reg [3];
    logic signed [PROD_W-1:0]  p1_reg [3];
    logic signed [PROD_W-1:0]  p2_reg [3];
    logic [CPROD_W-1:0]        cprod_reg [3];
    logic signed [CROSS_W-1:0] n_reg [3];
    logic signed [CROSS_W-1:0] nabs [3];
    logic [MAG_W-1:0]          mag_reg [3];
    logic [2*HI_W-1:0]         hh_reg [3];
    logic [HI_W+LO_W-1:0]      hl_reg [3];
    logic [2*LO_W-1:0]         ll_reg [3];
    logic [SQ_W-1:0]           sq6_reg [3];
    logic [SQ_W-1:0]           sq7_reg [3];
    logic [SUM_W-1:0]          s_reg;
    logic [COORD_W-1:0]        cen3_reg [3];
    logic [COORD_W-1:0]        cen4_reg [3];
    logic [COORD_W-1:0]        cen5_reg [3];
    logic [COORD_W-1:0]        cen6_reg [3];
    logic [COORD_W-1:0]        cen7_reg [3];
    logic [2:0]                neg4_reg;
    logic [2:0]                neg5_reg;
    logic [2:0]                neg6_reg;
    logic [2:0]                neg7_reg;

    // Gather vertex coordinates per axis
    always_comb begin
        va[0] = vtx_i.a_x; va[1] = vtx_i.a_y; va[2] = vtx_i.a_z;
        vb[0] = vtx_i.b_x; vb[1] = vtx_i.b_y; vb[2] = vtx_i.b_z;
        vc[0] = vtx_i.c_x; vc[1] = vtx_i.c_y; vc[2] = vtx_i.c_z;
    end

    // Stage 1: edge vectors from the first vertex, biased axis sums
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                e_reg[l] <= $signed({vb[l][COORD_W-1], vb[l]})
                          - $signed({va[l][COORD_W-1], va[l]});
                f_reg[l] <= $signed({vc[l][COORD_W-1], vc[l]})
                          - $signed({va[l][COORD_W-1], va[l]});
                u_reg[l] <= {{(CEN_W-COORD_W){va[l][COORD_W-1]}}, va[l]}
                          + {{(CEN_W-COORD_W){vb[l][COORD_W-1]}}, vb[l]}
                          + {{(CEN_W-COORD_W){vc[l][COORD_W-1]}}, vc[l]}
                          + CEN_BIAS;
            end
        end
    end

    // Stage 2: cross product partial products, divide-by-three multiply
    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg[0] <= e_reg[1] * f_reg[2];
            p2_reg[0] <= e_reg[2] * f_reg[1];
            p1_reg[1] <= e_reg[2] * f_reg[0];
            p2_reg[1] <= e_reg[0] * f_reg[2];
            p1_reg[2] <= e_reg[0] * f_reg[1];
            p2_reg[2] <= e_reg[1] * f_reg[0];
            for (int l = 0; l < 3; l++) begin
                cprod_reg[l] <= CPROD_W'(u_reg[l]) * CPROD_W'(RECIP_3);
            end
        end
    end

    // Stage 3: cross product components, centroid quotient
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                n_reg[l]    <= $signed({p1_reg[l][PROD_W-1], p1_reg[l]})
                             - $signed({p2_reg[l][PROD_W-1], p2_reg[l]});
                cen3_reg[l] <= cprod_reg[l][RECIP_SHIFT +: COORD_W];
            end
        end
    end

    // Stage 4: magnitude and sign
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            nabs[l] = n_reg[l][CROSS_W-1] ? -n_reg[l] : n_reg[l];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                mag_reg[l]  <= nabs[l][MAG_W-1:0];
                neg4_reg[l] <= n_reg[l][CROSS_W-1];
                cen4_reg[l] <= cen3_reg[l];
            end
        end
    end

    // Stage 5: split squaring into narrow partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                hh_reg[l] <= (2*HI_W)'(mag_reg[l][MAG_W-1:LO_W])
                           * (2*HI_W)'(mag_reg[l][MAG_W-1:LO_W]);
                hl_reg[l] <= (HI_W+LO_W)'(mag_reg[l][MAG_W-1:LO_W])
                           * (HI_W+LO_W)'(mag_reg[l][LO_W-1:0]);
                ll_reg[l] <= (2*LO_W)'(mag_reg[l][LO_W-1:0])
                           * (2*LO_W)'(mag_reg[l][LO_W-1:0]);
            end
            neg5_reg <= neg4_reg;
            for (int l = 0; l < 3; l++) begin
                cen5_reg[l] <= cen4_reg[l];
            end
        end
    end

    // Stage 6: recombine squares
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 3; l++) begin
                sq6_reg[l] <= (SQ_W'(hh_reg[l]) << (2*LO_W))
                            + (SQ_W'(hl_reg[l]) << (LO_W+1))
                            + SQ_W'(ll_reg[l]);
                cen6_reg[l] <= cen5_reg[l];
            end
            neg6_reg <= neg5_reg;
        end
    end

    // Stage 7: squared cross length
    always_ff @(posedge aclk) begin
        if (en) begin
            s_reg <= SUM_W'(sq6_reg[0]) + SUM_W'(sq6_reg[1]) + SUM_W'(sq6_reg[2]);
            for (int l = 0; l < 3; l++) begin
                sq7_reg[l]  <= sq6_reg[l];
                cen7_reg[l] <= cen6_reg[l];
            end
            neg7_reg <= neg6_reg;
        end
    end

    always_comb begin
        front_o.s   = s_reg;
        front_o.neg = neg7_reg;
        for (int l = 0; l < 3; l++) begin
            front_o.sq[l]  = sq7_reg[l];
            front_o.cen[l] = cen7_reg[l];
        end
    end

endmodule

FILE: src/tfg_sqrt.sv
// Pipelined integer square root of the squared cross length, one root bit
// per stage. Depends on tfg_pkg.
module tfg_sqrt (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [tfg_pkg::SUM_W-1:0]   s_i,
    output logic [tfg_pkg::ROOT_W-1:0]  root_o
);
    import tfg_pkg::*;

    logic [SUM_W-1:0]  s_reg    [ROOT_STAGES];
    logic [RREM_W-1:0] rem_reg  [ROOT_STAGES];
    logic [ROOT_W-1:0] root_reg [ROOT_STAGES];
    logic [SUM_W-1:0]  s_next    [ROOT_STAGES];
    logic [RREM_W-1:0] rem_next  [ROOT_STAGES];
    logic [ROOT_W-1:0] root_next [ROOT_STAGES];

    // Each stage brings down two radicand bits and tries the next root bit
    always_comb begin
        logic [SUM_W-1:0]  ps;
        logic [RREM_W-1:0] prem;
        logic [ROOT_W-1:0] proot;
        logic [RREM_W-1:0] cur;
        logic [RREM_W:0]   trial;
        logic              take;
        for (int k = 0; k < ROOT_STAGES; k++) begin
            if (k == 0) begin
                ps    = s_i;
                prem  = '0;
                proot = '0;
            end else begin
                ps    = s_reg[k-1];
                prem  = rem_reg[k-1];
                proot = root_reg[k-1];
            end
            cur   = {prem[RREM_W-3:0], ps[SUM_W-1-2*k -: 2]};
            trial = {1'b0, cur} - {1'b0, RREM_W'({proot, 2'b01})};
            take  = !trial[RREM_W];
            s_next[k]    = ps;
            rem_next[k]  = take ? trial[RREM_W-1:0] : cur;
            root_next[k] = {proot[ROOT_W-2:0], take};
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < ROOT_STAGES; k++) begin
                s_reg[k]    <= s_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign root_o = root_reg[ROOT_STAGES-1];

endmodule

FILE: src/tfg_norm.sv
// Pipelined quotient unit for the three unit-normal lanes: finds the largest
// k with k*k*S <= sq*2^34, one bit per stage. Depends on tfg_pkg.
module tfg_norm (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [tfg_pkg::SUM_W-1:0]         s_i,
    input  logic [2:0][tfg_pkg::SQ_W-1:0]     sq_i,
    output logic [2:0][tfg_pkg::KQ_W-1:0]     k_o
);
    import tfg_pkg::*;

    logic [NRM_W-1:0] s_reg  [NRM_STAGES];
    logic [NRM_W-1:0] s3_reg [NRM_STAGES];
    logic [NRM_W-1:0] r_reg  [NRM_STAGES][3];
    logic [NRM_W-1:0] x_reg  [NRM_STAGES][3];
    logic [KQ_W-1:0]  k_reg  [NRM_STAGES][3];
    logic [NRM_W-1:0] s_next  [NRM_STAGES];
    logic [NRM_W-1:0] s3_next [NRM_STAGES];
    logic [NRM_W-1:0] r_next  [NRM_STAGES][3];
    logic [NRM_W-1:0] x_next  [NRM_STAGES][3];
    logic [KQ_W-1:0]  k_next  [NRM_STAGES][3];

    // Restoring search: residual r against trial x = (4*k_hi + 1) * S
    always_comb begin
        logic [NRM_W-1:0] ps;
        logic [NRM_W-1:0] ps3;
        logic [NRM_W-1:0] pr;
        logic [NRM_W-1:0] px;
        logic [KQ_W-1:0]  pk;
        logic [NRM_W:0]   diff;
        logic             take;
        for (int j = 0; j < NRM_STAGES; j++) begin
            if (j == 0) begin
                ps  = NRM_W'(s_i);
                ps3 = ps + (ps << 1);
            end else begin
                ps  = s_reg[j-1];
                ps3 = s3_reg[j-1];
            end
            s_next[j]  = ps;
            s3_next[j] = ps3;
            for (int l = 0; l < 3; l++) begin
                if (j == 0) begin
                    pr = NRM_W'(sq_i[l]);
                    px = ps;
                    pk = '0;
                end else begin
                    pr = r_reg[j-1][l];
                    px = x_reg[j-1][l];
                    pk = k_reg[j-1][l];
                end
                diff = {1'b0, pr} - {1'b0, px};
                take = !diff[NRM_W];
                r_next[j][l] = take ? (diff[NRM_W-1:0] << 2) : (pr << 2);
                if (j == 0) begin
                    x_next[j][l] = take ? ((ps << 2) + ps) : ps;
                end else begin
                    x_next[j][l] = take ? ((px << 1) + ps3) : ((px << 1) - ps);
                end
                k_next[j][l] = {pk[KQ_W-2:0], take};
            end
        end
    end

    // Advance all stages together
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NRM_STAGES; j++) begin
                s_reg[j]  <= s_next[j];
                s3_reg[j] <= s3_next[j];
                for (int l = 0; l < 3; l++) begin
                    r_reg[j][l] <= r_next[j][l];
                    x_reg[j][l] <= x_next[j][l];
                    k_reg[j][l] <= k_next[j][l];
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            k_o[l] = k_reg[NRM_STAGES-1][l];
        end
    end

endmodule

FILE: src/triangle_facet_geometry_top.sv
// Triangle facet geometry: area, centroid and unit normal of one triangle.
// Top level; depends on tfg_pkg, tfg_front, tfg_sqrt and tfg_norm.
//
// Usage:
//   Input channel (s_valid/s_ready) takes the three vertices a, b, c as
//   signed Q7.16 coordinates. Result channel (m_valid/m_ready) returns the
//   area (Q.16, saturated), the centroid rounded to nearest, the unit normal
//   in Q1.16 and a degenerate flag. The APB port holds degenerate_limit at
//   byte address 0; the squared cross length is compared against it.
//   Throughput: one request per cycle unless a held result stalls the
//   pipeline. The 50-stage square root pipeline, one root bit per stage,
//   follows 7 cross-product stages.
//   All stages advance together; when a result is held with m_ready low the
//   whole pipeline holds and s_ready drops until the result is taken.
//   Reset clears every valid bit and degenerate_limit; data registers are
//   not reset.
module triangle_facet_geometry_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_a_x,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_a_y,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_a_z,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_b_x,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_b_y,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_b_z,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_c_x,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_c_y,
    input  logic signed [tfg_pkg::COORD_W-1:0]   s_c_z,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [tfg_pkg::AREA_W-1:0]           m_facet_area,
    output logic signed [tfg_pkg::COORD_W-1:0]   m_centroid_x,
    output logic signed [tfg_pkg::COORD_W-1:0]   m_centroid_y,
    output logic signed [tfg_pkg::COORD_W-1:0]   m_centroid_z,
    output logic signed [tfg_pkg::NORMAL_W-1:0]  m_normal_x,
    output logic signed [tfg_pkg::NORMAL_W-1:0]  m_normal_y,
    output logic signed [tfg_pkg::NORMAL_W-1:0]  m_normal_z,
    output logic                                 m_degenerate,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tfg_pkg::ADDR_W-1:0]           paddr,
    input  logic [tfg_pkg::DATA_W-1:0]           pwdata,
    output logic [tfg_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready
);
    import tfg_pkg::*;

    logic                     en;
    logic [PIPE_STAGES-1:0]   vld_reg;
    logic [DATA_W-1:0]        limit_reg;
    vtx_t                     vtx;
    front_t                   front;
    logic [ROOT_W-1:0]        root;
    logic [2:0][KQ_W-1:0]     kq;
    logic [2:0][UNIT_W-1:0]   unit;
    side_t                    side_in;
    side_t                    side_reg [ROOT_STAGES];
    logic [2:0][UNIT_W-1:0]   unit_reg [NRM_DELAY];
    logic [ROOT_W-1:0]        area_full;
    logic [NORMAL_W-1:0]      nrm [3];

    logic [AREA_W-1:0]        area_reg;
    logic [COORD_W-1:0]       cen_reg [3];
    logic [NORMAL_W-1:0]      nrm_reg [3];
    logic                     degen_reg;

    // Global advance: move when the output stage is empty or being taken
    assign en      = !vld_reg[PIPE_STAGES-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_STAGES-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_STAGES-2:0], s_valid};
        end
    end

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1] == REG_LIMIT) ? limit_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1] == REG_LIMIT) begin
            limit_reg <= pwdata;
        end
    end

    // Front end: cross product, squared length, centroid
    assign vtx = '{a_x: s_a_x, a_y: s_a_y, a_z: s_a_z,
                   b_x: s_b_x, b_y: s_b_y, b_z: s_b_z,
                   c_x: s_c_x, c_y: s_c_y, c_z: s_c_z};

    tfg_front u_front (
        .aclk    (aclk),
        .en      (en),
        .vtx_i   (vtx),
        .front_o (front)
    );

    tfg_sqrt u_sqrt (
        .aclk   (aclk),
        .en     (en),
        .s_i    (front.s),
        .root_o (root)
    );

    tfg_norm u_norm (
        .aclk (aclk),
        .en   (en),
        .s_i  (front.s),
        .sq_i (front.sq),
        .k_o  (kq)
    );

    // Side data that rides alongside the square root
    always_comb begin
        side_in.cen   = front.cen;
        side_in.neg   = front.neg;
        side_in.degen = (front.s[SUM_W-1:DATA_W] == '0)
                     && (front.s[DATA_W-1:0] <= limit_reg);
    end

    // Halve the quotient with rounding to nearest, cap at one
    always_comb begin
        logic [KQ_W:0] kp1;
        for (int l = 0; l < 3; l++) begin
            kp1 = {1'b0, kq[l]} + (KQ_W+1)'(1);
            if (kp1[KQ_W:1] > KQ_W'(NORMAL_ONE)) begin
                unit[l] = NORMAL_ONE;
            end else begin
                unit[l] = kp1[UNIT_W:1];
            end
        end
    end

    // Delay lines to line up with the root
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < ROOT_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            unit_reg[0] <= unit;
            for (int i = 1; i < NRM_DELAY; i++) begin
                unit_reg[i] <= unit_reg[i-1];
            end
        end
    end

    // Output stage: area shift and saturate, signed normals, zero when degenerate
    always_comb begin
        area_full = root >> (COORD_FRAC_BITS + 1);
        for (int l = 0; l < 3; l++) begin
            if (side_reg[ROOT_STAGES-1].degen) begin
                nrm[l] = '0;
            end else if (side_reg[ROOT_STAGES-1].neg[l]) begin
                nrm[l] = -{1'b0, unit_reg[NRM_DELAY-1][l]};
            end else begin
                nrm[l] = {1'b0, unit_reg[NRM_DELAY-1][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            area_reg  <= (area_full > AREA_MAX) ? AREA_MAX[AREA_W-1:0]
                                                : area_full[AREA_W-1:0];
            degen_reg <= side_reg[ROOT_STAGES-1].degen;
            for (int l = 0; l < 3; l++) begin
                cen_reg[l] <= side_reg[ROOT_STAGES-1].cen[l];
                nrm_reg[l] <= nrm[l];
            end
        end
    end

    assign m_facet_area = area_reg;
    assign m_centroid_x = cen_reg[0];
    assign m_centroid_y = cen_reg[1];
    assign m_centroid_z = cen_reg[2];
    assign m_normal_x   = nrm_reg[0];
    assign m_normal_y   = nrm_reg[1];
    assign m_normal_z   = nrm_reg[2];
    assign m_degenerate = degen_reg;

    // A degenerate facet carries a zero normal
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |->
            m_normal_x == '0 && m_normal_y == '0 && m_normal_z == '0)
        else $error("degenerate result with nonzero normal");

    // A proper facet always has some nonzero normal component
    a_nondegen_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_degenerate |->
            m_normal_x != '0 || m_normal_y != '0 || m_normal_z != '0)
        else $error("non-degenerate result with zero normal");

    // Normal components stay within plus or minus one
    a_normal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |->
            m_normal_x <= 18'sd65536 && m_normal_x >= -18'sd65536 &&
            m_normal_y <= 18'sd65536 && m_normal_y >= -18'sd65536 &&
            m_normal_z <= 18'sd65536 && m_normal_z >= -18'sd65536)
        else $error("normal component out of range");

endmodule
